@@ src/stq_pkg.sv @@
`default_nettype none
package stq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam logic [31:0] TPS_RESET = 32'd10000000;
	localparam int MS_PER_SEC = 1000;
	localparam int DIV_STEPS = 16;
	localparam logic [63:0] EMPTY_COMPARE = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] KIND_UPDATE = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	typedef struct packed {
		logic [63:0] expiry;
		logic [7:0]  tag;
		logic        notify;
	} entry_t;

	typedef enum logic [1:0] {
		OUT_ADD,
		OUT_FULL,
		OUT_FIRE,
		OUT_TICK
	} out_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_ADD,
		S_INS_RD,
		S_INS_CMP,
		S_ADD_OUT,
		S_FULL_OUT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_FIRE_RD,
		S_FIRE_CHK,
		S_TICK_OUT
	} state_t;

	typedef struct packed {
		logic     ld_in;
		logic     mul;
		logic     div_step;
		logic     add;
		logic     rd_en;
		logic     rd_prev;
		logic     ins_shift;
		logic     ins_place;
		logic     scan_hit;
		logic     scan_end_rd;
		logic     scan_end_empty;
		logic     fire_next;
		logic     out_ld;
		out_sel_t out_sel;
		logic     commit;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic full;
		logic div_done;
		logic idx_zero;
		logic idx_lt_count;
		logic idx_lt_due;
		logic ins_move;
		logic rd_due;
		logic rd_notify;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

@@ src/stq_ctrl.sv @@
`default_nettype none
module stq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire stq_pkg::status_t st,
	output stq_pkg::cmd_t        cmd
);

	stq_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.out_sel = stq_pkg::OUT_ADD;
		in_stall = 1'b1;
		unique case (state_q)
			stq_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					if (st.op == stq_pkg::OP_TICK) begin
						state_d = stq_pkg::S_SCAN_RD;
					end else if (st.full) begin
						state_d = stq_pkg::S_FULL_OUT;
					end else begin
						state_d = stq_pkg::S_MUL;
					end
				end
			end
			stq_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = stq_pkg::S_DIV;
			end
			stq_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_done) begin
					state_d = stq_pkg::S_ADD;
				end
			end
			stq_pkg::S_ADD: begin
				cmd.add = 1'b1;
				state_d = stq_pkg::S_INS_RD;
			end
			stq_pkg::S_INS_RD: begin
				if (st.idx_zero) begin
					cmd.ins_place = 1'b1;
					state_d = stq_pkg::S_ADD_OUT;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_prev = 1'b1;
					state_d = stq_pkg::S_INS_CMP;
				end
			end
			stq_pkg::S_INS_CMP: begin
				if (st.ins_move) begin
					cmd.ins_shift = 1'b1;
					state_d = stq_pkg::S_INS_RD;
				end else begin
					cmd.ins_place = 1'b1;
					state_d = stq_pkg::S_ADD_OUT;
				end
			end
			stq_pkg::S_ADD_OUT: begin
				cmd.out_sel = stq_pkg::OUT_ADD;
				if (st.out_free) begin
					cmd.out_ld = 1'b1;
					state_d = stq_pkg::S_IDLE;
				end
			end
			stq_pkg::S_FULL_OUT: begin
				cmd.out_sel = stq_pkg::OUT_FULL;
				if (st.out_free) begin
					cmd.out_ld = 1'b1;
					state_d = stq_pkg::S_IDLE;
				end
			end
			stq_pkg::S_SCAN_RD: begin
				if (st.idx_lt_count) begin
					cmd.rd_en = 1'b1;
					state_d = stq_pkg::S_SCAN_CMP;
				end else begin
					cmd.scan_end_empty = 1'b1;
					state_d = stq_pkg::S_FIRE_RD;
				end
			end
			stq_pkg::S_SCAN_CMP: begin
				if (st.rd_due) begin
					cmd.scan_hit = 1'b1;
					state_d = stq_pkg::S_SCAN_RD;
				end else begin
					cmd.scan_end_rd = 1'b1;
					state_d = stq_pkg::S_FIRE_RD;
				end
			end
			stq_pkg::S_FIRE_RD: begin
				if (st.idx_lt_due) begin
					cmd.rd_en = 1'b1;
					state_d = stq_pkg::S_FIRE_CHK;
				end else begin
					state_d = stq_pkg::S_TICK_OUT;
				end
			end
			stq_pkg::S_FIRE_CHK: begin
				cmd.out_sel = stq_pkg::OUT_FIRE;
				if (!st.rd_notify) begin
					cmd.fire_next = 1'b1;
					state_d = stq_pkg::S_FIRE_RD;
				end else if (st.out_free) begin
					cmd.out_ld = 1'b1;
					cmd.fire_next = 1'b1;
					state_d = stq_pkg::S_FIRE_RD;
				end
			end
			stq_pkg::S_TICK_OUT: begin
				cmd.out_sel = stq_pkg::OUT_TICK;
				if (st.out_free) begin
					cmd.out_ld = 1'b1;
					cmd.commit = 1'b1;
					state_d = stq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = stq_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/stq_dp.sv @@
`default_nettype none
module stq_dp #(
	parameter int DEPTH = stq_pkg::DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire stq_pkg::cmd_t cmd,
	output stq_pkg::status_t   st,
	input  wire logic [31:0]   tps,
	input  wire logic          op,
	input  wire logic [63:0]   now,
	input  wire logic [31:0]   delay,
	input  wire logic [7:0]    tag,
	input  wire logic          notify,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [1:0]         kind,
	output logic [7:0]         fired_tag,
	output logic [63:0]        compare_value,
	output logic               compare_written,
	output logic               last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	stq_pkg::entry_t mem [DEPTH];
	stq_pkg::entry_t rd_q;

	logic [63:0] now_q;
	logic [31:0] delay_q;
	logic [7:0]  tag_q;
	logic        notify_q;
	logic [63:0] work_q;
	logic [9:0]  rem_q;
	logic [3:0]  div_cnt_q;
	logic [63:0] exp_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] due_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic [63:0] first_q;
	logic [63:0] cmp_q;
	logic        wflag_q;

	logic [63:0] work_d;
	logic [9:0]  rem_d;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic        out_free;

	// ring position of logical entry i
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(i);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return AW'(s);
	endfunction

	// divide by 1000, four quotient bits a step
	always_comb begin
		logic [10:0] r2;
		work_d = work_q;
		rem_d = rem_q;
		for (int k = 0; k < 4; k++) begin
			r2 = {rem_d, work_d[63]};
			work_d = {work_d[62:0], 1'b0};
			if (r2 >= 11'(stq_pkg::MS_PER_SEC)) begin
				r2 = r2 - 11'(stq_pkg::MS_PER_SEC);
				work_d[0] = 1'b1;
			end
			rem_d = r2[9:0];
		end
	end

	assign rd_addr = cmd.rd_prev ? phys(head_q, idx_q - CW'(1)) : phys(head_q, idx_q);
	assign wr_addr = phys(head_q, idx_q);
	assign out_free = !out_valid || !out_stall;

	// entry memory
	always_ff @(posedge clk) begin
		if (cmd.ins_shift) begin
			mem[wr_addr] <= rd_q;
		end else if (cmd.ins_place) begin
			mem[wr_addr] <= '{expiry: exp_q, tag: tag_q, notify: notify_q};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// request and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			now_q <= now;
			delay_q <= delay;
			tag_q <= tag;
			notify_q <= notify;
		end
		if (cmd.mul) begin
			work_q <= 64'(delay_q) * 64'(tps);
			rem_q <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			work_q <= work_d;
			rem_q <= rem_d;
			div_cnt_q <= div_cnt_q + 4'd1;
		end
		if (cmd.add) begin
			exp_q <= now_q + work_q;
		end
		if (cmd.ins_place) begin
			wflag_q <= (idx_q == '0);
		end
		if (cmd.scan_end_rd) begin
			cmp_q <= rd_q.expiry;
		end else if (cmd.scan_end_empty) begin
			cmp_q <= stq_pkg::EMPTY_COMPARE;
		end
		if (cmd.scan_end_rd || cmd.scan_end_empty) begin
			due_q <= idx_q;
		end
		if (cmd.ins_place && idx_q == '0) begin
			first_q <= exp_q;
		end else if (cmd.commit) begin
			first_q <= cmp_q;
		end
	end

	// queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			count_q <= '0;
			head_q <= '0;
		end else begin
			if (cmd.ld_in || cmd.scan_end_rd || cmd.scan_end_empty) begin
				idx_q <= '0;
			end else if (cmd.add) begin
				idx_q <= count_q;
			end else if (cmd.ins_shift) begin
				idx_q <= idx_q - CW'(1);
			end else if (cmd.scan_hit || cmd.fire_next) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.ins_place) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.commit) begin
				count_q <= count_q - due_q;
				head_q <= phys(head_q, due_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			case (cmd.out_sel)
				stq_pkg::OUT_ADD: begin
					kind <= stq_pkg::KIND_UPDATE;
					fired_tag <= '0;
					compare_value <= first_q;
					compare_written <= wflag_q;
					last <= 1'b1;
				end
				stq_pkg::OUT_FULL: begin
					kind <= stq_pkg::KIND_REJECT;
					fired_tag <= '0;
					compare_value <= (count_q != '0) ? first_q : stq_pkg::EMPTY_COMPARE;
					compare_written <= 1'b0;
					last <= 1'b1;
				end
				stq_pkg::OUT_FIRE: begin
					kind <= stq_pkg::KIND_FIRED;
					fired_tag <= rd_q.tag;
					compare_value <= cmp_q;
					compare_written <= 1'b0;
					last <= 1'b0;
				end
				default: begin
					kind <= stq_pkg::KIND_UPDATE;
					fired_tag <= '0;
					compare_value <= cmp_q;
					compare_written <= 1'b1;
					last <= 1'b1;
				end
			endcase
		end
	end

	// status to the controller
	always_comb begin
		st.op = op;
		st.full = (count_q == CW'(DEPTH));
		st.div_done = (div_cnt_q == 4'(stq_pkg::DIV_STEPS - 1));
		st.idx_zero = (idx_q == '0);
		st.idx_lt_count = (idx_q < count_q);
		st.idx_lt_due = (idx_q < due_q);
		st.ins_move = (rd_q.expiry > exp_q);
		st.rd_due = (rd_q.expiry <= now_q);
		st.rd_notify = rd_q.notify;
		st.out_free = out_free;
	end

endmodule
`default_nettype wire

@@ src/sorted_timer_queue.sv @@
`default_nettype none
// Sorted timer queue: keeps up to DEPTH timers ordered by expiry in a ring
// memory with one read and one write port. After the cycle that takes it, an
// add converts the delay (one multiply, sixteen divide-by-1000 steps of four
// bits, one add), moves every pending entry with a later expiry one place up
// through the memory port, places the new timer at the front or behind an
// earlier entry, and gives its result. An add to a full queue gives only its
// reject. A tick reads the entries in order to find the due ones, ends the scan
// at the first entry not yet due or at the end of the queue, then reads each due
// entry again to report or drop it, and ends with the final result. Every result
// waits while the output is stalled. A new request is taken once the last result
// of the previous one sits in the output register.
module sorted_timer_queue #(
	parameter int DEPTH = stq_pkg::DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [63:0] now,
	input  wire logic [31:0] delay,
	input  wire logic [7:0]  tag,
	input  wire logic        notify,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       fired_tag,
	output logic [63:0]      compare_value,
	output logic             compare_written,
	output logic             last
);

	logic [31:0] tps_q;
	stq_pkg::cmd_t cmd;
	stq_pkg::status_t st;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? tps_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= stq_pkg::TPS_RESET;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			tps_q <= pwdata;
		end
	end

	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	stq_dp #(.DEPTH(DEPTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.tps             (tps_q),
		.op              (op),
		.now             (now),
		.delay           (delay),
		.tag             (tag),
		.notify          (notify),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.fired_tag       (fired_tag),
		.compare_value   (compare_value),
		.compare_written (compare_written),
		.last            (last)
	);

	// a fired result never closes a request nor programs the compare
	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == stq_pkg::KIND_FIRED |-> !last && !compare_written)
		else $error("fired result marked last or written");

	// update and reject results always close a request
	a_update_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == stq_pkg::KIND_UPDATE || kind == stq_pkg::KIND_REJECT) |-> last)
		else $error("closing result without last");

	// a reject never programs the compare
	a_reject_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == stq_pkg::KIND_REJECT |-> !compare_written)
		else $error("reject wrote compare");

endmodule
`default_nettype wire
